/* hdl/fat12_cluster_chain_reader_core_assert.svh */
// Assertion macros shared by the cluster chain reader modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FAT12_CLUSTER_CHAIN_READER_CORE_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_READER_CORE_ASSERT_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define FCC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fcc assertion failed");
// Condition must never be true outside reset.
`define FCC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("fcc forbidden condition seen");
`else
`define FCC_ASSERT(lbl, clk, rst_n, prop)
`define FCC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* hdl/fcc_pkg.sv */
// Types, constants and codes of the FAT12 cluster chain reader.
// No dependencies; used by every module of the block.
package fcc_pkg;

  // Sizing of the table and the clusters.
  localparam int MAX_CLUSTERS  = 4096;
  localparam int CLUSTER_BYTES = 1024;
  localparam int TABLE_DEPTH   = (MAX_CLUSTERS * 3) / 2;
  localparam int BANK_DEPTH    = (TABLE_DEPTH + 1) / 2;
  localparam int BANK_AW       = $clog2(BANK_DEPTH);

  // Field widths.
  localparam int CLUSTER_W = 12;
  localparam int POS_W     = CLUSTER_W + 1;
  localparam int IDX_W     = 13;
  localparam int COUNT_W   = 22;
  localparam int ADDR_W    = 24;
  localparam int BASE_W    = 23;
  localparam int OFFS_W    = $clog2(CLUSTER_BYTES);
  localparam int BIC_W     = OFFS_W + 1;
  localparam int LINK_W    = COUNT_W - OFFS_W;

  localparam logic [CLUSTER_W-1:0] EOC_FIRST = 12'hFF8;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-3:0] REG_DATA_BASE = '0;
  localparam logic [BASE_W-1:0] DATA_BASE_RST = 23'd14336;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_OPEN  = 2'd1,
    OP_NEXT  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_WRITTEN   = 3'd0,
    ST_OPENED    = 3'd1,
    ST_ADDR      = 3'd2,
    ST_END       = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_BOUND
  } state_e;

  typedef struct packed {
    op_e                 opcode;
    logic [IDX_W-1:0]    table_byte_index;
    logic [7:0]          table_byte_value;
    logic [CLUSTER_W-1:0] start_cluster;
    logic [COUNT_W-1:0]  byte_offset;
    logic [COUNT_W-1:0]  byte_count;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] data_address;
    status_e           status;
  } res_t;

  // Table write request from the controller.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } tbl_wr_t;

endpackage

/* hdl/fcc_cfg.sv */
// APB register file of the chain reader: holds the data area base address.
// Depends on fcc_pkg.
module fcc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fcc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [fcc_pkg::BASE_W-1:0] data_base_o
);
  import fcc_pkg::*;

  logic [BASE_W-1:0] data_base_q, data_base_d;
  logic              sel_base;

  assign sel_base = (paddr[CFG_AW-1:2] == REG_DATA_BASE);
  assign pready   = 1'b1;

  // Register write on the access cycle.
  always_comb begin
    data_base_d = data_base_q;
    if (psel && penable && pwrite && sel_base) begin
      data_base_d = pwdata[BASE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_base_q <= DATA_BASE_RST;
    end else begin
      data_base_q <= data_base_d;
    end
  end

  // Read back; unmapped addresses read zero.
  assign prdata      = sel_base ? {{(32 - BASE_W){1'b0}}, data_base_q} : 32'd0;
  assign data_base_o = data_base_q;

endmodule

/* hdl/fcc_table.sv */
// FAT table store: two byte banks (even and odd byte index) so both bytes of
// a 12-bit entry come out of one read, plus the entry decode. Uses fcc_pkg.
module fcc_table (
  input  logic                          clk_i,
  input  fcc_pkg::tbl_wr_t              wr_i,
  input  logic [fcc_pkg::CLUSTER_W-1:0] rd_cluster_i,
  output logic [fcc_pkg::CLUSTER_W-1:0] entry_o
);
  import fcc_pkg::*;

  logic [7:0] even_mem [BANK_DEPTH];
  logic [7:0] odd_mem  [BANK_DEPTH];

  logic [POS_W-1:0]   pos, pos_nx;
  logic [BANK_AW-1:0] even_addr, odd_addr, wr_addr;
  logic               b0_ok, b1_ok;
  logic [7:0]         even_q, odd_q;
  logic               b0_ok_q, b1_ok_q, pos_odd_q, n_odd_q;
  logic [7:0]         b0, b1;

  // Byte position of the entry: 3n/2 and the byte after it.
  assign pos    = POS_W'(rd_cluster_i) + POS_W'(rd_cluster_i >> 1);
  assign pos_nx = pos + POS_W'(1);
  assign b0_ok  = (32'(pos) < TABLE_DEPTH);
  assign b1_ok  = (32'(pos_nx) < TABLE_DEPTH);

  // The odd-indexed byte of the pair sits at pos/2, the even one at (pos+1)/2.
  assign odd_addr  = pos[BANK_AW:1];
  assign even_addr = pos_nx[BANK_AW:1];
  assign wr_addr   = wr_i.idx[BANK_AW:1];

  // Bank memories: one write, one registered read each.
  always_ff @(posedge clk_i) begin
    if (wr_i.we && !wr_i.idx[0]) begin
      even_mem[wr_addr] <= wr_i.data;
    end
    even_q <= even_mem[even_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we && wr_i.idx[0]) begin
      odd_mem[wr_addr] <= wr_i.data;
    end
    odd_q <= odd_mem[odd_addr];
  end

  // Alignment flags follow the read data.
  always_ff @(posedge clk_i) begin
    b0_ok_q   <= b0_ok;
    b1_ok_q   <= b1_ok;
    pos_odd_q <= pos[0];
    n_odd_q   <= rd_cluster_i[0];
  end

  // Entry decode; bytes past the table read as zero.
  always_comb begin
    b0 = pos_odd_q ? odd_q : even_q;
    b1 = pos_odd_q ? even_q : odd_q;
    if (!b0_ok_q) begin
      b0 = 8'd0;
    end
    if (!b1_ok_q) begin
      b1 = 8'd0;
    end
    if (n_odd_q) begin
      entry_o = {b1, b0[7:4]};
    end else begin
      entry_o = {b1[3:0], b0};
    end
  end

endmodule

/* hdl/fcc_ctrl.sv */
// Request sequencer of the chain reader: file position state, chain walk,
// result register. Depends on fcc_pkg and the assertion macro header.
`include "fat12_cluster_chain_reader_core_assert.svh"

module fcc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  fcc_pkg::req_t                 req_i,
  output logic                          busy_o,
  output logic                          done_o,
  output fcc_pkg::res_t                 res_o,
  input  logic [fcc_pkg::BASE_W-1:0]    data_base_i,
  output fcc_pkg::tbl_wr_t              wr_o,
  output logic [fcc_pkg::CLUSTER_W-1:0] rd_cluster_o,
  input  logic [fcc_pkg::CLUSTER_W-1:0] entry_i
);
  import fcc_pkg::*;

  state_e               state_q, state_d;
  logic [CLUSTER_W-1:0] cluster_q, cluster_d;
  logic [BIC_W-1:0]     bic_q, bic_d;
  logic [COUNT_W-1:0]   rem_q, rem_d;
  logic                 ended_q, ended_d;
  logic [LINK_W-1:0]    links_q, links_d;
  logic                 done_q, done_d;
  res_t                 res_q, res_d;

  logic                 eoc;
  logic [CLUSTER_W-1:0] addr_cluster;
  logic [BIC_W-1:0]     addr_byte;
  logic [ADDR_W-1:0]    addr_sum;
  logic [LINK_W-1:0]    open_links;

  assign eoc        = (entry_i >= EOC_FIRST);
  assign open_links = req_i.byte_offset[COUNT_W-1:OFFS_W];

  // Byte address: at a boundary the freshly decoded cluster at byte zero.
  assign addr_cluster = (state_q == S_BOUND) ? entry_i : cluster_q;
  assign addr_byte    = (state_q == S_BOUND) ? '0 : bic_q;
  assign addr_sum     = ADDR_W'(data_base_i)
                      + ADDR_W'({addr_cluster, {OFFS_W{1'b0}}})
                      + ADDR_W'(addr_byte);

  // Next state, position update and result.
  always_comb begin
    state_d   = state_q;
    cluster_d = cluster_q;
    bic_d     = bic_q;
    rem_d     = rem_q;
    ended_d   = ended_q;
    links_d   = links_q;
    done_d    = 1'b0;
    res_d     = '{data_address: '0, status: ST_WRITTEN};
    wr_o      = '{we: 1'b0, idx: req_i.table_byte_index, data: req_i.table_byte_value};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (req_i.opcode)
            OP_WRITE: begin
              wr_o.we = (32'(req_i.table_byte_index) < TABLE_DEPTH);
              done_d  = 1'b1;
            end
            OP_OPEN: begin
              cluster_d = req_i.start_cluster;
              bic_d     = BIC_W'(req_i.byte_offset[OFFS_W-1:0]);
              rem_d     = req_i.byte_count;
              ended_d   = 1'b0;
              links_d   = open_links;
              if (open_links == '0) begin
                done_d       = 1'b1;
                res_d.status = ST_OPENED;
              end else begin
                state_d = S_WALK;
              end
            end
            OP_NEXT: begin
              if (rem_q == '0) begin
                done_d       = 1'b1;
                res_d.status = ST_EXHAUSTED;
              end else if (ended_q) begin
                done_d       = 1'b1;
                res_d.status = ST_END;
              end else if (32'(bic_q) < CLUSTER_BYTES) begin
                done_d       = 1'b1;
                res_d        = '{data_address: addr_sum, status: ST_ADDR};
                bic_d        = bic_q + BIC_W'(1);
                rem_d        = rem_q - COUNT_W'(1);
              end else begin
                state_d = S_BOUND;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // One link per cycle: the entry of the current cluster is on entry_i.
      S_WALK: begin
        if (eoc) begin
          ended_d      = 1'b1;
          done_d       = 1'b1;
          res_d.status = ST_OPENED;
          state_d      = S_IDLE;
        end else begin
          cluster_d = entry_i;
          links_d   = links_q - LINK_W'(1);
          if (links_q == LINK_W'(1)) begin
            done_d       = 1'b1;
            res_d.status = ST_OPENED;
            state_d      = S_IDLE;
          end
        end
      end

      // Cluster boundary on a next request: follow one link, then emit.
      S_BOUND: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (eoc) begin
          ended_d      = 1'b1;
          res_d.status = ST_END;
        end else begin
          cluster_d = entry_i;
          bic_d     = BIC_W'(1);
          rem_d     = rem_q - COUNT_W'(1);
          res_d     = '{data_address: addr_sum, status: ST_ADDR};
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cluster_q <= '0;
      bic_q     <= '0;
      rem_q     <= '0;
      ended_q   <= 1'b1;
      links_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cluster_q <= cluster_d;
      bic_q     <= bic_d;
      rem_q     <= rem_d;
      ended_q   <= ended_d;
      links_q   <= links_d;
      done_q    <= done_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // The table is always read for the cluster held next cycle.
  assign rd_cluster_o = cluster_d;
  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign res_o        = res_q;

  // A delivered address consumed exactly one byte of the count.
  `FCC_ASSERT(a_addr_consumes, clk_i, rst_ni,
    (done_q && res_q.status == ST_ADDR) |-> ((rem_q + COUNT_W'(1)) == $past(rem_q)))
  // Only address results carry a nonzero address.
  `FCC_ASSERT(a_addr_zero, clk_i, rst_ni,
    (done_q && res_q.status != ST_ADDR) |-> (res_q.data_address == '0))
  // The walk runs only with links left on a live chain.
  `FCC_ASSERT(a_walk_live, clk_i, rst_ni,
    (state_q == S_WALK) |-> ((links_q != '0) && !ended_q))
  // After an address the position lies past the cluster start, at most at its end.
  `FCC_ASSERT_NEVER(a_bic_range, clk_i, rst_ni,
    done_q && res_q.status == ST_ADDR && (bic_q == '0 || 32'(bic_q) > CLUSTER_BYTES))

endmodule

/* hdl/fat12_cluster_chain_reader_core.sv */
// Top level of the FAT12 cluster chain reader.
// Depends on fcc_pkg, fcc_cfg, fcc_table and fcc_ctrl.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+--------------------------
//  request   | start_i, busy_o               | req_i (fcc_pkg::req_t)
//  result    | done_o (one-cycle strobe)     | res_o (fcc_pkg::res_t)
//  config    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Every request gets one result, strobed in the cycle after the one in which
// the request completes. Writes, opens without a skip and next-byte requests
// that need no table read complete in the idle state and leave busy_o low.
// An open that skips L clusters walks them in S_WALK, one table read per link;
// a next-byte request at a cluster boundary waits in S_BOUND for its table read.
// After reset the position is empty (chain ended, count zero); the table is
// not cleared and must be loaded before it is walked. The receiver cannot stall.
module fat12_cluster_chain_reader_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  fcc_pkg::req_t              req_i,
  output logic                       busy_o,
  output logic                       done_o,
  output fcc_pkg::res_t              res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fcc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import fcc_pkg::*;

  logic [BASE_W-1:0]    data_base;
  tbl_wr_t              tbl_wr;
  logic [CLUSTER_W-1:0] rd_cluster;
  logic [CLUSTER_W-1:0] entry;

  // Configuration registers.
  fcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .data_base_o (data_base)
  );

  // Table memory and entry decode.
  fcc_table u_table (
    .clk_i        (clk_i),
    .wr_i         (tbl_wr),
    .rd_cluster_i (rd_cluster),
    .entry_o      (entry)
  );

  // Sequencer.
  fcc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_i        (req_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .res_o        (res_o),
    .data_base_i  (data_base),
    .wr_o         (tbl_wr),
    .rd_cluster_o (rd_cluster),
    .entry_i      (entry)
  );

endmodule
